// File: sv/ipv6fmt_pkg.sv
// ============================================================================
// ipv6fmt_pkg - shared types, constants and helpers of the IPv6 text formatter
// Holds the descriptor passed from the classifier to the character sequencer,
// the queue status group, the ASCII codes and the digit conversion functions.
// ============================================================================
package ipv6fmt_pkg;

    // Default depth of the descriptor queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0]  CH_COLON   = 7'h3a;
    localparam logic [6:0]  CH_DOT     = 7'h2e;
    localparam logic [6:0]  CH_ZERO    = 7'h30;
    localparam logic [6:0]  CH_LOWER_A = 7'h61;
    localparam logic [6:0]  CH_LOWER_F = 7'h66;
    localparam logic [15:0] MAPPED_TAG = 16'hffff;

    // Address viewed as eight groups; element 7 is group 0 (bits 127..112).
    typedef logic [7:0][15:0] t_groups;

    // One classified address.
    typedef struct packed {
        logic [127:0]     addr;
        logic             run_ok;    // a zero run of two or more groups exists
        logic [2:0]       run_base;  // first group of that run
        logic [3:0]       run_end;   // group just past the run (may be 8)
        logic             dotted;    // low 32 bits go out in dotted decimal
        logic             mapped;    // zero run of five groups; marks the ffff prefix when dotted
        logic [3:0][11:0] bcd;       // three BCD digits of each low byte
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        logic [6:0] c;
        if (n < 4'd10) begin
            c = CH_ZERO + {3'b000, n};
        end else begin
            c = CH_LOWER_A + {3'b000, n} - 7'd10;
        end
        return c;
    endfunction

    // Index of the first nibble to print, leading zeros suppressed.
    function automatic logic [1:0] hex_start(input logic [15:0] g);
        logic [1:0] s;
        if (g[15:12] != 4'd0) begin
            s = 2'd3;
        end else if (g[11:8] != 4'd0) begin
            s = 2'd2;
        end else if (g[7:4] != 4'd0) begin
            s = 2'd1;
        end else begin
            s = 2'd0;
        end
        return s;
    endfunction

    // Byte to three BCD digits {hundreds, tens, ones}; tens uses x*205>>11.
    function automatic logic [11:0] byte_bcd(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [3:0]  o;
        if (v >= 8'd200) begin
            h = 2'd2;
            r = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            h = 2'd1;
            r = 7'(v - 8'd100);
        end else begin
            h = 2'd0;
            r = v[6:0];
        end
        p = 15'(r) * 15'd205;
        t = p[14:11];
        o = 4'(r - {3'b000, t} * 7'd10);
        return {2'b00, h, t, o};
    endfunction

    // Index of the first decimal digit to print.
    function automatic logic [1:0] dec_start(input logic [11:0] b);
        logic [1:0] s;
        if (b[11:8] != 4'd0) begin
            s = 2'd2;
        end else if (b[7:4] != 4'd0) begin
            s = 2'd1;
        end else begin
            s = 2'd0;
        end
        return s;
    endfunction

endpackage

// File: sv/ipv6fmt_ifs.sv
// ============================================================================
// ipv6fmt interfaces - request channels of the IPv6 text formatter
// Address input channel, text output channel and register write channel.
// ============================================================================
interface ipv6fmt_addr_if;
    logic        valid;
    logic        ready;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    modport source (output valid, addr_upper, addr_lower, input ready);
    modport sink   (input valid, addr_upper, addr_lower, output ready);
endinterface

interface ipv6fmt_text_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;
    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface ipv6fmt_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: sv/ipv6fmt_front.sv
// ============================================================================
// ipv6fmt_front - address intake and classification
// Finds the first longest zero run, picks hex or dotted form and converts the
// low bytes to BCD, producing one descriptor per accepted request.
// ============================================================================
module ipv6fmt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ipv6fmt_addr_if.sink         i_addr,
    ipv6fmt_cfg_if.sink          i_cfg,
    input  ipv6fmt_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output ipv6fmt_pkg::t_desc   o_desc
);

    logic                 r_embed;
    ipv6fmt_pkg::t_groups gv;
    logic [7:0]           zero;
    logic [3:0]           cur_len;
    logic [2:0]           cur_base;
    logic [3:0]           best_len;
    logic [2:0]           best_base;
    logic                 run_ok;

    assign i_cfg.ready  = 1'b1;
    assign i_addr.ready = !i_q_stat.full;
    assign o_push       = i_addr.valid && i_addr.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_embed <= 1'b1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_embed <= i_cfg.data;
        end
    end

    assign gv = {i_addr.addr_upper, i_addr.addr_lower};

    // Zero run scan in group order; a strictly longer run replaces the best.
    always_comb begin
        cur_len   = 4'd0;
        cur_base  = 3'd0;
        best_len  = 4'd0;
        best_base = 3'd0;
        for (int i = 0; i < 8; i++) begin
            zero[i] = (gv[3'(7 - i)] == 16'd0);
            if (zero[i]) begin
                if (cur_len == 4'd0) begin
                    cur_base = 3'(i);
                end
                cur_len = cur_len + 4'd1;
            end else begin
                if (cur_len > best_len) begin
                    best_len  = cur_len;
                    best_base = cur_base;
                end
                cur_len = 4'd0;
            end
        end
        if (cur_len > best_len) begin
            best_len  = cur_len;
            best_base = cur_base;
        end
    end

    assign run_ok = (best_len >= 4'd2);

    always_comb begin
        o_desc.addr     = gv;
        o_desc.run_ok   = run_ok;
        o_desc.run_base = best_base;
        o_desc.run_end  = {1'b0, best_base} + best_len;
        o_desc.mapped   = (best_len == 4'd5);
        o_desc.dotted   = run_ok && (best_base == 3'd0)
                          && (((best_len == 4'd6) && r_embed)
                              || ((best_len == 4'd5) && (gv[2] == ipv6fmt_pkg::MAPPED_TAG)));
        for (int j = 0; j < 4; j++) begin
            o_desc.bcd[j] = ipv6fmt_pkg::byte_bcd(i_addr.addr_lower[31 - 8 * j -: 8]);
        end
    end

endmodule

// File: sv/ipv6fmt_fifo.sv
// ============================================================================
// ipv6fmt_fifo - descriptor queue
// Short register queue that decouples the classifier from the sequencer.
// ============================================================================
module ipv6fmt_fifo #(
    parameter int DEPTH = ipv6fmt_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ipv6fmt_pkg::t_desc   i_desc,
    input  logic                 i_pop,
    output ipv6fmt_pkg::t_desc   o_desc,
    output ipv6fmt_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipv6fmt_pkg::t_desc r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    assign o_desc       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: sv/ipv6fmt_back.sv
// ============================================================================
// ipv6fmt_back - character sequencer
// Walks one descriptor and produces one text character per cycle into an
// output register while the sink takes them, in hex group form or in dotted decimal form.
// ============================================================================
module ipv6fmt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipv6fmt_pkg::t_desc   i_desc,
    input  ipv6fmt_pkg::t_q_stat i_q_stat,
    output logic                 o_pop,
    ipv6fmt_text_if.source       o_text
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GRP  = 7'b0000010,
        S_RUN  = 7'b0000100,
        S_DIG  = 7'b0001000,
        S_PFX  = 7'b0010000,
        S_DEC  = 7'b0100000,
        S_DOT  = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    ipv6fmt_pkg::t_desc   r_cur;
    logic [3:0]           r_gi, n_gi;   // group index, or byte index in dotted form
    logic [1:0]           r_di, n_di;   // digit position inside the group or byte
    logic [2:0]           r_ci, n_ci;   // prefix character index
    logic                 r_out_valid;
    logic [6:0]           r_char;
    logic                 r_last;

    logic                 adv;
    logic                 emit;
    logic [6:0]           e_char;
    logic                 e_last;
    logic                 dig_step;
    logic [1:0]           d_sel;
    ipv6fmt_pkg::t_groups gv;
    logic [15:0]          grp;
    logic [11:0]          bcd_cur;

    assign adv   = !r_out_valid || o_text.ready;
    assign o_pop = (r_state == S_IDLE) && !i_q_stat.empty;

    assign gv      = r_cur.addr;
    assign grp     = gv[~r_gi[2:0]];
    assign bcd_cur = r_cur.bcd[r_gi[1:0]];
    assign d_sel   = (r_state == S_DIG) ? r_di : ipv6fmt_pkg::hex_start(grp);

    always_comb begin
        n_state  = r_state;
        n_gi     = r_gi;
        n_di     = r_di;
        n_ci     = r_ci;
        emit     = 1'b0;
        e_char   = ipv6fmt_pkg::CH_COLON;
        e_last   = 1'b0;
        dig_step = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_gi    = 4'd0;
                    n_ci    = 3'd0;
                    n_state = i_desc.dotted ? S_PFX : S_GRP;
                end
            end
            S_GRP: begin
                if (adv) begin
                    emit = 1'b1;
                    if (r_cur.run_ok && (r_gi[2:0] == r_cur.run_base)) begin
                        n_gi    = r_cur.run_end;
                        n_state = S_RUN;
                    end else if (r_gi != 4'd0) begin
                        n_di    = ipv6fmt_pkg::hex_start(grp);
                        n_state = S_DIG;
                    end else begin
                        dig_step = 1'b1;
                    end
                end
            end
            S_RUN: begin
                if (adv) begin
                    emit = 1'b1;
                    if (r_gi[3]) begin
                        // The run reaches the end of the address.
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_di    = ipv6fmt_pkg::hex_start(grp);
                        n_state = S_DIG;
                    end
                end
            end
            S_DIG: begin
                if (adv) begin
                    emit     = 1'b1;
                    dig_step = 1'b1;
                end
            end
            S_PFX: begin
                if (adv) begin
                    emit   = 1'b1;
                    e_char = (r_ci inside {[3'd2:3'd5]}) ? ipv6fmt_pkg::CH_LOWER_F
                                                        : ipv6fmt_pkg::CH_COLON;
                    if ((!r_cur.mapped && (r_ci == 3'd1)) || (r_ci == 3'd6)) begin
                        n_gi    = 4'd0;
                        n_di    = ipv6fmt_pkg::dec_start(r_cur.bcd[0]);
                        n_state = S_DEC;
                    end else begin
                        n_ci = r_ci + 3'd1;
                    end
                end
            end
            S_DEC: begin
                if (adv) begin
                    emit   = 1'b1;
                    e_char = ipv6fmt_pkg::CH_ZERO + {3'b000, bcd_cur[4 * r_di +: 4]};
                    if (r_di != 2'd0) begin
                        n_di = r_di - 2'd1;
                    end else if (r_gi[1:0] == 2'd3) begin
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DOT;
                    end
                end
            end
            S_DOT: begin
                if (adv) begin
                    emit    = 1'b1;
                    e_char  = ipv6fmt_pkg::CH_DOT;
                    n_gi    = r_gi + 4'd1;
                    n_di    = ipv6fmt_pkg::dec_start(r_cur.bcd[r_gi[1:0] + 2'd1]);
                    n_state = S_DEC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (dig_step) begin
            e_char = ipv6fmt_pkg::hex_char(grp[4 * d_sel +: 4]);
            if (d_sel != 2'd0) begin
                n_di    = d_sel - 2'd1;
                n_state = S_DIG;
            end else if (r_gi == 4'd7) begin
                e_last  = 1'b1;
                n_state = S_IDLE;
            end else begin
                n_gi    = r_gi + 4'd1;
                n_state = S_GRP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gi        <= 4'd0;
            r_di        <= 2'd0;
            r_ci        <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gi    <= n_gi;
            r_di    <= n_di;
            r_ci    <= n_ci;
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_desc;
        end
        if (adv && emit) begin
            r_char <= e_char;
            r_last <= e_last;
        end
    end

    assign o_text.valid     = r_out_valid;
    assign o_text.char_code = r_char;
    assign o_text.last_char = r_last;

endmodule

// File: sv/ipv6_address_text_formatter.sv
// ============================================================================
// ipv6_address_text_formatter - IPv6 address to printable text, one character
// per request on the output channel, with the final character marked.
// First character path: queue, sequencer load in the idle state, output register.
// Throughput: an address of 2 to 39 characters holds the sequencer for a load in
// the idle state, then one character per cycle while the sink takes each one.
// Reset: synchronous, active low; queue empty, sequencer idle, embed bit 1.
// ============================================================================
module ipv6_address_text_formatter #(
    parameter int QUEUE_DEPTH = ipv6fmt_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ipv6fmt_cfg_if.sink    i_cfg,
    ipv6fmt_addr_if.sink   i_addr,
    ipv6fmt_text_if.source o_text
);

    // The front classifies each address in the cycle it is accepted: it finds
    // the first longest zero run, decides between hex groups and dotted
    // decimal, and precomputes the BCD digits of the low four bytes. The
    // resulting descriptor goes into a short queue, so a new address can be
    // taken while the previous one is still being printed.
    ipv6fmt_pkg::t_desc   push_desc;
    ipv6fmt_pkg::t_desc   head_desc;
    ipv6fmt_pkg::t_q_stat q_stat;
    logic                 push;
    logic                 pop;

    ipv6fmt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_addr   (i_addr),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_desc   (push_desc)
    );

    ipv6fmt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_desc  (head_desc),
        .o_stat  (q_stat)
    );

    // The back loads one descriptor when idle, then walks it character by
    // character. The output register lets it continue as long as the sink
    // takes each character; a stalled sink simply freezes the sequencer.
    ipv6fmt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_desc   (head_desc),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_text   (o_text)
    );

    // An accepted address is visible in the queue on the next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_stat.empty)
        else $error("accepted address did not land in the queue");

    // The queue can never look both full and empty.
    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // A character that is not taken stays on the channel unchanged.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_text.valid && !o_text.ready) |=> (o_text.valid
            && $stable(o_text.char_code) && $stable(o_text.last_char)))
        else $error("stalled character changed or dropped");

endmodule
